// ===== rtl/periodic_task_delta_queue_unit_defines.svh =====
// Assertion macros shared by the checker of the periodic task delta queue.
// No dependencies; the using module must have i_clk and i_rst_n in scope.
`ifndef PERIODIC_TASK_DELTA_QUEUE_UNIT_DEFINES_SVH
`define PERIODIC_TASK_DELTA_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTDQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, checked out of reset.
`define PTDQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/ptdq_pkg.sv =====
// Types and constants of the periodic task delta queue.
// No dependencies; imported by every RTL module of the block.
package ptdq_pkg;

    localparam int TASK_W = 4;
    localparam int OPC_W  = 2;
    localparam int PER_W  = 31;

    localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPC_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OPC_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [TASK_W-1:0] task_id;
        logic [PER_W-1:0]  period_ticks;
    } t_in_item;

    typedef struct packed {
        logic [TASK_W-1:0] expired_task;
        logic              released;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_DEC,
        CELL_KILL,
        CELL_INSERT,
        CELL_POPINS
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [TASK_W-1:0] task_id;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KILL,
        ST_INSERT,
        ST_DEC,
        ST_POP
    } t_state;

endpackage

// ===== rtl/ptdq_cell.sv =====
// One queue cell: holds one entry (task, ticks left until release).
// Depends on ptdq_pkg; chained by periodic_task_delta_queue_unit.
module ptdq_cell #(
    parameter int DUE_W = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptdq_pkg::t_cell_cmd         i_cmd,
    input  logic [DUE_W-1:0]            i_due,
    input  logic                        i_l_valid,
    input  logic [ptdq_pkg::TASK_W-1:0] i_l_task,
    input  logic [DUE_W-1:0]            i_l_due,
    input  logic                        i_l_le,
    input  logic                        i_l_kill,
    input  logic                        i_r_valid,
    input  logic [ptdq_pkg::TASK_W-1:0] i_r_task,
    input  logic [DUE_W-1:0]            i_r_due,
    input  logic                        i_r_le,
    output logic                        o_valid,
    output logic [ptdq_pkg::TASK_W-1:0] o_task,
    output logic [DUE_W-1:0]            o_due,
    output logic                        o_le,
    output logic                        o_kill
);
    import ptdq_pkg::*;

    logic              r_valid, n_valid;
    logic [TASK_W-1:0] r_task, n_task;
    logic [DUE_W-1:0]  r_due, n_due;
    logic              w_match;

    // le: this entry is due no later than the entry being placed
    assign o_le    = r_valid && (r_due <= i_due);
    assign w_match = r_valid && (r_task == i_cmd.task_id);
    assign o_kill  = i_l_kill | w_match;

    always_comb begin
        n_valid = r_valid;
        n_task  = r_task;
        n_due   = r_due;
        case (i_cmd.op)
            CELL_DEC: begin
                if (r_valid) begin
                    n_due = r_due - DUE_W'(1);
                end
            end
            CELL_KILL: begin
                // removed entry at or left of here: close the gap
                if (o_kill) begin
                    n_valid = i_r_valid;
                    n_task  = i_r_task;
                    n_due   = i_r_due;
                end
            end
            CELL_INSERT: begin
                if (!i_l_le) begin
                    n_valid = i_l_valid;
                    n_task  = i_l_task;
                    n_due   = i_l_due;
                end else if (!o_le) begin
                    n_valid = 1'b1;
                    n_task  = i_cmd.task_id;
                    n_due   = i_due;
                end
            end
            CELL_POPINS: begin
                // head leaves; entries ahead of the new place move left
                if (i_r_le) begin
                    n_valid = i_r_valid;
                    n_task  = i_r_task;
                    n_due   = i_r_due;
                end else if (o_le) begin
                    n_valid = 1'b1;
                    n_task  = i_cmd.task_id;
                    n_due   = i_due;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_task <= n_task;
        r_due  <= n_due;
    end

    assign o_valid = r_valid;
    assign o_task  = r_task;
    assign o_due   = r_due;

endmodule

// ===== rtl/periodic_task_delta_queue_unit.sv =====
// Top level of the periodic task delta queue: control FSM, task tables, cell row.
// Depends on ptdq_pkg and ptdq_cell.
//
// Periodic task release queue. The queue is a row of MAX_TASKS cells kept
// sorted by release time; each cell holds a task and its ticks to release
// (the running sum of the delta list), so equal deadlines keep arrival order.
// Opcode add (re)queues a task one period out and clears its finished flag;
// a period of 0 counts as 1 and a period above 2^TICK_BITS-1 saturates.
// Opcode finished sets the task's flag. Opcode tick ages every entry by one
// and then pops each due entry in order, giving one transfer per expired task
// (released = flag was set, else overrun) with last set on the final one;
// each popped task goes back in one period later. Adds and finishes naming
// task slots at or above MAX_TASKS, and unknown opcodes, are dropped without
// results. A finished or ignored item ends at accept; an add steps through
// accept, remove old entry, insert; a tick through accept, age, then one
// pop-and-reinsert per cycle in the cell row while the result output is not
// stalled, until no due head is left. The output register lets the next
// item be accepted while the last result of a tick still waits. No clearing
// pass after reset.
module periodic_task_delta_queue_unit #(
    parameter int MAX_TASKS = 16,
    parameter int TICK_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptdq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptdq_pkg::t_out_item o_out_data
);
    import ptdq_pkg::*;

    // task_id is 4 bits, so at most 16 slots can ever be named
    localparam int NUM_SLOTS = (MAX_TASKS < (1 << TASK_W)) ? MAX_TASKS : (1 << TASK_W);
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [PER_W-1:0] PERIOD_MAX = PER_W'((64'd1 << TICK_BITS) - 64'd1);

    t_state             r_state, n_state;
    logic [TASK_W-1:0]  r_add_task;
    logic [TICK_BITS-1:0] r_add_due;
    logic [TICK_BITS-1:0] r_period [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_finished;
    logic               r_out_valid;
    t_out_item          r_out;

    // cell row, padded: index 0 is the left edge, N+1 the right edge
    logic                 w_valid [MAX_TASKS+2];
    logic [TASK_W-1:0]    w_task  [MAX_TASKS+2];
    logic [TICK_BITS-1:0] w_due   [MAX_TASKS+2];
    logic                 w_le    [MAX_TASKS+2];
    logic                 w_kill  [MAX_TASKS+1];

    t_cell_cmd            w_cmd;
    logic [TICK_BITS-1:0] w_bcast_due;
    logic                 w_in_xfer;
    logic                 w_slot_ok;
    logic [PER_W-1:0]     w_per_sat;
    logic                 w_head_zero;
    logic                 w_next_zero;
    logic                 w_pop_go;
    logic [SLOT_W-1:0]    w_head_slot;
    logic [SLOT_W-1:0]    w_in_slot;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_slot_ok  = (32'(i_in_data.task_id) < MAX_TASKS);
    assign w_in_slot  = i_in_data.task_id[SLOT_W-1:0];

    always_comb begin
        if (i_in_data.period_ticks == '0) begin
            w_per_sat = PER_W'(1);
        end else if (i_in_data.period_ticks > PERIOD_MAX) begin
            w_per_sat = PERIOD_MAX;
        end else begin
            w_per_sat = i_in_data.period_ticks;
        end
    end

    // head never sits at zero outside a tick, so a zero head means "due now"
    assign w_head_zero = w_valid[1] && (w_due[1] == '0);
    assign w_next_zero = w_valid[2] && (w_due[2] == '0);
    assign w_head_slot = w_task[1][SLOT_W-1:0];
    assign w_pop_go    = (r_state == ST_POP) && w_head_zero && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_data.opcode == OP_TICK) begin
                        n_state = ST_DEC;
                    end else if (i_in_data.opcode == OP_ADD && w_slot_ok) begin
                        n_state = ST_KILL;
                    end
                end
            end
            ST_KILL:   n_state = ST_INSERT;
            ST_INSERT: n_state = ST_IDLE;
            ST_DEC:    n_state = ST_POP;
            ST_POP: begin
                if (!w_head_zero || (w_pop_go && !w_next_zero)) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // cell row command
    always_comb begin
        w_cmd.op      = CELL_HOLD;
        w_cmd.task_id = r_add_task;
        w_bcast_due   = r_add_due;
        unique case (r_state)
            ST_KILL:   w_cmd.op = CELL_KILL;
            ST_INSERT: w_cmd.op = CELL_INSERT;
            ST_DEC:    w_cmd.op = CELL_DEC;
            ST_POP: begin
                if (w_pop_go) begin
                    w_cmd.op      = CELL_POPINS;
                    w_cmd.task_id = w_task[1];
                    w_bcast_due   = r_period[w_head_slot];
                end
            end
            default:   w_cmd.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_finished  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer && w_slot_ok) begin
                if (i_in_data.opcode == OP_FINISH) begin
                    r_finished[w_in_slot] <= 1'b1;
                end else if (i_in_data.opcode == OP_ADD) begin
                    r_finished[w_in_slot] <= 1'b0;
                end
            end
            if (w_pop_go) begin
                r_finished[w_head_slot] <= 1'b0;
                r_out_valid             <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_slot_ok && i_in_data.opcode == OP_ADD) begin
            r_add_task           <= i_in_data.task_id;
            r_add_due            <= TICK_BITS'(w_per_sat);
            r_period[w_in_slot]  <= TICK_BITS'(w_per_sat);
        end
        if (w_pop_go) begin
            r_out.expired_task <= w_task[1];
            r_out.released     <= r_finished[w_head_slot];
            r_out.last         <= !w_next_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // row edges
    assign w_valid[0]           = 1'b0;
    assign w_task[0]            = '0;
    assign w_due[0]             = '0;
    assign w_le[0]              = 1'b1;
    assign w_kill[0]            = 1'b0;
    assign w_valid[MAX_TASKS+1] = 1'b0;
    assign w_task[MAX_TASKS+1]  = '0;
    assign w_due[MAX_TASKS+1]   = '0;
    assign w_le[MAX_TASKS+1]    = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        ptdq_cell #(
            .DUE_W (TICK_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_due     (w_bcast_due),
            .i_l_valid (w_valid[g]),
            .i_l_task  (w_task[g]),
            .i_l_due   (w_due[g]),
            .i_l_le    (w_le[g]),
            .i_l_kill  (w_kill[g]),
            .i_r_valid (w_valid[g+2]),
            .i_r_task  (w_task[g+2]),
            .i_r_due   (w_due[g+2]),
            .i_r_le    (w_le[g+2]),
            .o_valid   (w_valid[g+1]),
            .o_task    (w_task[g+1]),
            .o_due     (w_due[g+1]),
            .o_le      (w_le[g+1]),
            .o_kill    (w_kill[g+1])
        );
    end

endmodule

// ===== rtl/ptdq_checker.sv =====
// Port-level checker of the periodic task delta queue, bound to the top level.
// Depends on ptdq_pkg and periodic_task_delta_queue_unit_defines.svh.
`include "periodic_task_delta_queue_unit_defines.svh"

module ptdq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ptdq_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ptdq_pkg::t_out_item o_out_data
);
    import ptdq_pkg::*;

    // stalled result holds
    `PTDQ_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // a tick always goes busy for its aging cycle
    `PTDQ_ASSERT_NXT(a_tick_busy, i_in_valid && o_in_ready && i_in_data.opcode == OP_TICK, !o_in_ready)
    // only a tick produces results
    `PTDQ_ASSERT_NXT(a_no_spurious, i_in_valid && o_in_ready && i_in_data.opcode != OP_TICK, !$rose(o_out_valid))
    // back to idle only after the last result of a tick
    `PTDQ_ASSERT_IMP(a_idle_last, o_in_ready && o_out_valid, o_out_data.last)

endmodule

bind periodic_task_delta_queue_unit ptdq_checker u_ptdq_checker (.*);

// ===== test/periodic_task_delta_queue_unit_test.sv =====
// Self-checking testbench for periodic_task_delta_queue_unit: directed table, then random traffic.
// Depends on ptdq_pkg and the RTL of the block; the expected expiries come from a predictor here.
module periodic_task_delta_queue_unit_test;
    import ptdq_pkg::*;

    localparam int NTASK          = 16;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off under pressure
    localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before the run is declared hung
    localparam int DRAIN_CYCLES   = 40;    // settle time after the last expected expiry

    // Opcode 3 has no meaning; the block must drop it.
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [PER_W-1:0] PERIOD_TOP = {PER_W{1'b1}};

    // Bus signals; those driven here are known from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;

    // Idle rates of both sides (percent of cycles) and the hold-off request.
    int         sender_idle_pct   = 0;
    int         receiver_idle_pct = 0;
    bit         hold_request      = 1'b0;

    int         items_sent  = 0;
    int         errors      = 0;
    int         idle_cycles = 0;

    // Expiries still owed by the block, oldest first.
    t_out_item  pending_expiries[$];

    // Predictor state: release queue as a delta list plus per-task tables.
    logic [TASK_W-1:0] rq_task  [NTASK];
    logic [31:0]       rq_delta [NTASK];
    int                rq_count = 0;
    logic [PER_W-1:0]  period_tab [NTASK];
    bit                done_flag  [NTASK];

    // Directed table: n_typed < 0 means the row is checked against the predictor.
    typedef struct {
        t_in_item  item;
        int        n_typed;
        t_out_item r0;
        t_out_item r1;
    } t_directed_row;

    t_directed_row directed_rows[$];

    periodic_task_delta_queue_unit #(
        .MAX_TASKS(NTASK),
        .TICK_BITS(PER_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Remove entry pos; its delta folds into the entry behind it.
    function automatic void rq_drop(int pos);
        if (pos >= rq_count)
            return;
        if (pos + 1 < rq_count)
            rq_delta[pos + 1] += rq_delta[pos];
        for (int i = pos; i + 1 < rq_count; i++) begin
            rq_task[i]  = rq_task[i + 1];
            rq_delta[i] = rq_delta[i + 1];
        end
        rq_count--;
    endfunction

    // Insert behind every entry due no later, so equal deadlines stay FIFO.
    function automatic void rq_insert(logic [TASK_W-1:0] t, logic [31:0] ticks);
        int          pos;
        logic [31:0] rem;
        pos = 0;
        rem = ticks;
        if (rq_count >= NTASK)
            return;
        while (pos < rq_count && rem >= rq_delta[pos]) begin
            rem -= rq_delta[pos];
            pos++;
        end
        for (int i = rq_count; i > pos; i--) begin
            rq_task[i]  = rq_task[i - 1];
            rq_delta[i] = rq_delta[i - 1];
        end
        rq_task[pos]  = t;
        rq_delta[pos] = rem;
        rq_count++;
        if (pos + 1 < rq_count)
            rq_delta[pos + 1] -= rem;
    endfunction

    // Apply one accepted item to the predictor and return the expiries it causes.
    // Task slots cannot exceed the table at 4 bits, and a 31-bit period cannot
    // exceed the saturation point, so neither case needs handling here.
    function automatic void predict_expiries(input t_in_item it, output t_out_item res[$]);
        logic [PER_W-1:0]  per;
        logic [TASK_W-1:0] t;
        int                budget;
        t_out_item         hit;
        res = {};
        case (it.opcode)
            OP_ADD: begin
                per = (it.period_ticks == '0) ? PER_W'(1) : it.period_ticks;
                // re-add: old entry goes away first
                for (int i = 0; i < rq_count; i++) begin
                    if (rq_task[i] == it.task_id) begin
                        rq_drop(i);
                        break;
                    end
                end
                period_tab[it.task_id] = per;
                done_flag[it.task_id]  = 1'b0;
                rq_insert(it.task_id, {1'b0, per});
            end
            OP_FINISH: begin
                done_flag[it.task_id] = 1'b1;
            end
            OP_TICK: begin
                if (rq_count > 0) begin
                    if (rq_delta[0] > 0)
                        rq_delta[0]--;
                    // at most one expiry per entry queued at the start of the tick
                    budget = rq_count;
                    while (budget > 0 && rq_count > 0 && rq_delta[0] == 0) begin
                        t = rq_task[0];
                        budget--;
                        rq_drop(0);
                        hit.expired_task = t;
                        hit.released     = done_flag[t];
                        hit.last         = 1'b0;
                        res.push_back(hit);
                        done_flag[t] = 1'b0;
                        rq_insert(t, {1'b0, period_tab[t]});
                    end
                    if (res.size() > 0) begin
                        hit      = res.pop_back();
                        hit.last = 1'b1;
                        res.push_back(hit);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one item, wait for its transfer, then book the expected expiries.
    // Typed rows supply their own expectations; the predictor still runs so
    // its state stays in step with the block.
    task automatic send_item(input t_in_item it, input int n_typed,
                             input t_out_item first_typed, input t_out_item second_typed);
        t_out_item res[$];
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_expiries(it, res);
        if (n_typed >= 0) begin
            res = {};
            if (n_typed > 0)
                res.push_back(first_typed);
            if (n_typed > 1)
                res.push_back(second_typed);
        end
        foreach (res[k])
            pending_expiries.push_back(res[k]);
        if (it.opcode != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_op(input logic [OPC_W-1:0] op, input logic [TASK_W-1:0] id,
                           input logic [PER_W-1:0] per);
        t_in_item it;
        it.opcode       = op;
        it.task_id      = id;
        it.period_ticks = per;
        send_item(it, -1, '0, '0);
    endtask

    function automatic t_out_item expiry(logic [TASK_W-1:0] t, logic rel, logic fin);
        t_out_item r;
        r.expired_task = t;
        r.released     = rel;
        r.last         = fin;
        return r;
    endfunction

    function automatic t_directed_row mk_row(logic [OPC_W-1:0] op, logic [TASK_W-1:0] id,
                                             logic [PER_W-1:0] per, int n,
                                             t_out_item a, t_out_item b);
        t_directed_row row;
        row.item.opcode       = op;
        row.item.task_id      = id;
        row.item.period_ticks = per;
        row.n_typed           = n;
        row.r0                = a;
        row.r1                = b;
        return row;
    endfunction

    // Random traffic until the item count reaches upto. Mostly well-formed
    // bursts (a few adds with short periods, then ticks with finishes in
    // between) so tasks really expire; the rest is noise and long periods.
    task automatic run_random(input int upto);
        int pick;
        int n;
        while (items_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                n = $urandom_range(4, 1);
                repeat (n)
                    send_op(OP_ADD, TASK_W'($urandom_range(15)), PER_W'($urandom_range(5)));
                n = $urandom_range(8, 2);
                repeat (n) begin
                    if ($urandom_range(1) == 1)
                        send_op(OP_FINISH, TASK_W'($urandom_range(15)), PER_W'($urandom));
                    send_op(OP_TICK, TASK_W'($urandom_range(15)), PER_W'($urandom));
                end
            end else if (pick < 85) begin
                // anything goes, including the unused opcode
                send_op(OPC_W'($urandom_range(3)), TASK_W'($urandom_range(15)),
                        PER_W'($urandom));
            end else if (pick < 93) begin
                // far-off release: top of the range or a wide random value
                send_op(OP_ADD, TASK_W'($urandom_range(15)),
                        ($urandom_range(1) == 1) ? PERIOD_TOP : PER_W'($urandom));
            end else begin
                n = $urandom_range(3, 1);
                repeat (n)
                    send_op(OP_FINISH, TASK_W'($urandom_range(15)), '0);
                send_op(OP_TICK, '0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, or a long hold-off when asked for one
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    if (k > 0)
                        @(posedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each expiry transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_expiry
        t_out_item want;
        bit        bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_expiries.size() == 0) begin
                $display("%0t: expected no expiry, got task %0d released %0b last %0b",
                         $time, o_out_data.expired_task, o_out_data.released,
                         o_out_data.last);
                errors++;
            end else begin
                want = pending_expiries.pop_front();
                bad  = 1'b0;
                if (o_out_data.expired_task !== want.expired_task)
                    bad = 1'b1;
                if (o_out_data.released !== want.released)
                    bad = 1'b1;
                if (o_out_data.last !== want.last)
                    bad = 1'b1;
                if (bad) begin
                    $display("%0t: expected task %0d released %0b last %0b, got task %0d released %0b last %0b",
                             $time, want.expired_task, want.released, want.last,
                             o_out_data.expired_task, o_out_data.released,
                             o_out_data.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles without a transfer on either channel. The longest
    // legal gap is the receiver hold-off plus a burst of 16 expiries at a
    // heavy receiver idle rate; the limit is many times that.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("periodic_task_delta_queue_unit: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed table. Early rows are simple enough to type the answer in:
        // empty queue, the unused opcode, zero period, finished on an idle
        // task, FIFO order of equal deadlines, an overrun next to a release.
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,            0, '0, '0));
        directed_rows.push_back(mk_row(OP_UNUSED, 4'd5,  31'd9,         0, '0, '0));
        directed_rows.push_back(mk_row(OP_FINISH, 4'd15, '0,            0, '0, '0));
        directed_rows.push_back(mk_row(OP_ADD,    4'd0,  '0,            0, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,            1,
                                       expiry(4'd0, 1'b0, 1'b1), '0));
        directed_rows.push_back(mk_row(OP_FINISH, 4'd0,  '0,            0, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,            1,
                                       expiry(4'd0, 1'b1, 1'b1), '0));
        directed_rows.push_back(mk_row(OP_ADD,    4'd15, 31'd1,         0, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,            2,
                                       expiry(4'd0, 1'b0, 1'b0),
                                       expiry(4'd15, 1'b0, 1'b1)));
        directed_rows.push_back(mk_row(OP_ADD,    4'd7,  PERIOD_TOP,    0, '0, '0));
        directed_rows.push_back(mk_row(OP_FINISH, 4'd15, '0,            0, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,            2,
                                       expiry(4'd0, 1'b0, 1'b0),
                                       expiry(4'd15, 1'b1, 1'b1)));
        // From here on the predictor supplies the answers.
        directed_rows.push_back(mk_row(OP_ADD,    4'd0,  31'd3,        -1, '0, '0));
        directed_rows.push_back(mk_row(OP_ADD,    4'd3,  31'h2AAAAAAA, -1, '0, '0));
        directed_rows.push_back(mk_row(OP_ADD,    4'd3,  31'd2,        -1, '0, '0));
        directed_rows.push_back(mk_row(OP_ADD,    4'd9,  31'h55555555, -1, '0, '0));
        directed_rows.push_back(mk_row(OP_FINISH, 4'd3,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_ADD,    4'd9,  31'd2,        -1, '0, '0));
        directed_rows.push_back(mk_row(OP_FINISH, 4'd9,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_TICK,   4'd0,  '0,           -1, '0, '0));
        directed_rows.push_back(mk_row(OP_UNUSED, 4'd15, PERIOD_TOP,    0, '0, '0));

        // First idle pattern: sender rarely idles, receiver mostly does.
        sender_idle_pct   = 12;
        receiver_idle_pct = 79;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].n_typed,
                      directed_rows[r].r0, directed_rows[r].r1);

        run_random(165);

        // Second idle pattern: the other way round.
        sender_idle_pct   = 79;
        receiver_idle_pct = 12;
        run_random(300);

        // No idling. First a long receiver hold-off while every task is due
        // each tick, so 16 expiries per tick pile up and the input stalls.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 1'b1;
        for (int id = 0; id < NTASK; id++)
            send_op(OP_ADD, TASK_W'(id), PER_W'(1));
        repeat (4)
            send_op(OP_TICK, '0, '0);
        run_random(430);

        i_in_valid <= 1'b0;

        // Drain every owed expiry, then give the block time to show strays.
        while (pending_expiries.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("periodic_task_delta_queue_unit: match");
        end else begin
            $display("periodic_task_delta_queue_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptdq_pkg.sv
rtl/ptdq_cell.sv
rtl/periodic_task_delta_queue_unit.sv
rtl/ptdq_checker.sv
test/periodic_task_delta_queue_unit_test.sv
